// ----- src/bfs_pkg.sv -----
// shared constants, types and functions of the bmp24 frame serializer
package bfs_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int CNT_W       = DIM_W + 1;
   localparam int CFG_W       = 13;
   localparam int CLAMP_W     = ((CFG_W > CNT_W) ? CFG_W : CNT_W) + 1;
   localparam int CHAN_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int HDR_BYTES   = 54;
   localparam int IDX_W       = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int PROD_W      = 2 * CNT_W + 3;
   localparam int SIZE_W      = (PROD_W > 32) ? PROD_W : 32;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
   localparam logic [7:0]  BMP_OFFSET    = 8'd54;
   localparam logic [7:0]  BMP_INFO_SIZE = 8'd40;
   localparam logic [7:0]  BMP_PLANES    = 8'd1;
   localparam logic [7:0]  BMP_DEPTH     = 8'd24;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // one pixel as classified by the front end
   typedef struct packed {
      logic              hdr;
      logic [1:0]        pad;
      logic              done;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
   } bfs_desc_type;

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CLAMP_W'(v) > CLAMP_W'(MAX_DIM)) begin
         r = CNT_W'(MAX_DIM);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   // q8.8 to byte: saturate above 1.0, else v*255 >> 8
   function automatic logic [BYTE_W-1:0] chan_byte(input logic [CHAN_W-1:0] v);
      logic [16:0]       prod;
      logic [BYTE_W-1:0] r;
      prod = {v[8:0], 8'b0} - 17'(v[8:0]);
      if (v > CHAN_W'(256)) begin
         r = 8'hFF;
      end else begin
         r = prod[15:8];
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                                  input logic [31:0] size,
                                                  input logic [31:0] w,
                                                  input logic [31:0] h);
      logic [BYTE_W-1:0] r;
      case (idx)
         6'd0:    r = BMP_MAGIC[7:0];
         6'd1:    r = BMP_MAGIC[15:8];
         6'd2:    r = size[7:0];
         6'd3:    r = size[15:8];
         6'd4:    r = size[23:16];
         6'd5:    r = size[31:24];
         6'd10:   r = BMP_OFFSET;
         6'd14:   r = BMP_INFO_SIZE;
         6'd18:   r = w[7:0];
         6'd19:   r = w[15:8];
         6'd20:   r = w[23:16];
         6'd21:   r = w[31:24];
         6'd22:   r = h[7:0];
         6'd23:   r = h[15:8];
         6'd24:   r = h[23:16];
         6'd25:   r = h[31:24];
         6'd26:   r = BMP_PLANES;
         6'd28:   r = BMP_DEPTH;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- src/bfs_if.sv -----
// pixel and byte stream channel interfaces
interface bfs_req_if;
   logic                       valid;
   logic                       ready;
   logic [bfs_pkg::CHAN_W-1:0] pixel_red;
   logic [bfs_pkg::CHAN_W-1:0] pixel_green;
   logic [bfs_pkg::CHAN_W-1:0] pixel_blue;

   modport source (output valid, output pixel_red, output pixel_green,
                   output pixel_blue, input ready);
   modport sink   (input valid, input pixel_red, input pixel_green,
                   input pixel_blue, output ready);
endinterface

interface bfs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bfs_pkg::BYTE_W-1:0] out_byte;
   logic                       last_of_run;
   logic                       frame_done;

   modport source (output valid, output out_byte, output last_of_run,
                   output frame_done, input ready);
   modport sink   (input valid, input out_byte, input last_of_run,
                   input frame_done, output ready);
endinterface

// ----- src/bfs_front.sv -----
// front end: takes pixels, converts channels, tracks column and row
module bfs_front (
   input  logic                      clock,
   input  logic                      reset,
   bfs_req_if.sink                   req_ch,
   input  logic [bfs_pkg::CNT_W-1:0] width_clamped,
   input  logic [bfs_pkg::CNT_W-1:0] height_clamped,
   input  logic                      queue_full,
   output logic                      push,
   output bfs_pkg::bfs_desc_type     push_desc
);

   logic [bfs_pkg::DIM_W-1:0] column_ff, column_in;
   logic [bfs_pkg::DIM_W-1:0] row_ff, row_in;
   logic [bfs_pkg::CNT_W-1:0] col_next;
   logic [bfs_pkg::CNT_W-1:0] row_next;
   logic                      row_end;
   logic                      frame_end;

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      col_next  = bfs_pkg::CNT_W'(column_ff) + bfs_pkg::CNT_W'(1);
      row_next  = bfs_pkg::CNT_W'(row_ff) + bfs_pkg::CNT_W'(1);
      row_end   = col_next >= width_clamped;
      frame_end = row_end && (row_next >= height_clamped);

      push_desc.hdr   = (column_ff == '0) && (row_ff == '0);
      push_desc.pad   = row_end ? width_clamped[1:0] : 2'd0;
      push_desc.done  = frame_end;
      push_desc.blue  = bfs_pkg::chan_byte(req_ch.pixel_blue);
      push_desc.green = bfs_pkg::chan_byte(req_ch.pixel_green);
      push_desc.red   = bfs_pkg::chan_byte(req_ch.pixel_red);

      column_in = column_ff;
      row_in    = row_ff;
      if (push) begin
         if (row_end) begin
            column_in = '0;
            row_in    = frame_end ? '0 : row_next[bfs_pkg::DIM_W-1:0];
         end else begin
            column_in = col_next[bfs_pkg::DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- src/bfs_queue.sv -----
// small descriptor queue between front and back
module bfs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bfs_pkg::bfs_desc_type push_desc,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output bfs_pkg::bfs_desc_type head
);

   bfs_pkg::bfs_desc_type      slot_ff [bfs_pkg::QUEUE_DEPTH];
   logic [bfs_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bfs_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == bfs_pkg::QCNT_W'(bfs_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + bfs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bfs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + bfs_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + bfs_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/bfs_back.sv -----
// back end: walks header, pixel and padding bytes onto the output register
module bfs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bfs_pkg::CNT_W-1:0] width_clamped,
   input  logic [bfs_pkg::CNT_W-1:0] height_clamped,
   input  logic                      head_valid,
   input  bfs_pkg::bfs_desc_type     head,
   output logic                      pop,
   bfs_rsp_if.source                 rsp_ch
);

   logic [bfs_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       started_ff, started_in;
   logic [31:0]                size_ff;
   logic [bfs_pkg::PROD_W-1:0] row_bytes;
   logic [bfs_pkg::SIZE_W-1:0] size_full;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bfs_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       done_ff, done_in;
   logic [bfs_pkg::IDX_W-1:0]  cur_idx;
   logic [bfs_pkg::IDX_W-1:0]  last_idx;
   logic                       adv;
   logic                       emit;
   logic                       at_last;

   // file size from the current geometry, registered
   always_comb begin
      row_bytes = (bfs_pkg::PROD_W'(width_clamped) * bfs_pkg::PROD_W'(3)
                   + bfs_pkg::PROD_W'(3)) & ~bfs_pkg::PROD_W'(3);
      size_full = bfs_pkg::SIZE_W'(height_clamped) * bfs_pkg::SIZE_W'(row_bytes)
                  + bfs_pkg::SIZE_W'(bfs_pkg::HDR_BYTES);
   end

   always_ff @(posedge clock) begin
      size_ff <= size_full[31:0];
   end

   always_comb begin
      adv      = !rsp_valid_ff || rsp_ch.ready;
      cur_idx  = started_ff ? idx_ff
               : (head.hdr ? '0 : bfs_pkg::IDX_W'(bfs_pkg::HDR_BYTES));
      last_idx = bfs_pkg::IDX_W'(bfs_pkg::HDR_BYTES + 2) + bfs_pkg::IDX_W'(head.pad);
      at_last  = cur_idx == last_idx;
      emit     = head_valid && adv;
      pop      = emit && at_last;

      if (cur_idx < bfs_pkg::IDX_W'(bfs_pkg::HDR_BYTES)) begin
         byte_in = bfs_pkg::hdr_byte(cur_idx, size_ff, 32'(width_clamped),
                                     32'(height_clamped));
      end else if (cur_idx == bfs_pkg::IDX_W'(bfs_pkg::HDR_BYTES)) begin
         byte_in = head.blue;
      end else if (cur_idx == bfs_pkg::IDX_W'(bfs_pkg::HDR_BYTES + 1)) begin
         byte_in = head.green;
      end else if (cur_idx == bfs_pkg::IDX_W'(bfs_pkg::HDR_BYTES + 2)) begin
         byte_in = head.red;
      end else begin
         byte_in = '0;
      end
      last_in = at_last;
      done_in = at_last && head.done;

      rsp_valid_in = adv ? emit : rsp_valid_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      if (emit) begin
         if (at_last) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            idx_in     = cur_idx + bfs_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.last_of_run = last_ff;
   assign rsp_ch.frame_done  = done_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> last_ff)
      else $error("frame_done without last_of_run");

   a_started_has_head: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> head_valid)
      else $error("byte walk running with empty queue");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> idx_ff <= last_idx)
      else $error("byte index beyond end of run");

endmodule

// ----- src/bmp24_frame_serializer.sv -----
// top level of the bmp24 frame serializer: registers, front, queue and back
//
//  port group | direction | carries
//  req_ch     | in        | one pixel: pixel_red, pixel_green, pixel_blue (q8.8)
//  rsp_ch     | out       | one file byte: out_byte, last_of_run, frame_done
//  csr_*      | in/out    | apb register port: image_width, image_height
//
// one output byte per cycle while rsp_ch is ready; a pixel gives 3 bytes, plus 54 for a header
// and 0 to 3 for row padding, all through the single byte-wide output register
// pixels are accepted in back-to-back cycles until the 4-entry queue fills
// synchronous active-high reset: width 640, height 480, counters at frame start
// a stall on rsp_ch holds the output byte; the queue absorbs input meanwhile
module bmp24_frame_serializer (
   input  logic                       clock,
   input  logic                       reset,
   bfs_req_if.sink                    req_ch,
   bfs_rsp_if.source                  rsp_ch,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [bfs_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [bfs_pkg::DATA_W-1:0] csr_pwdata,
   output logic [bfs_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [bfs_pkg::CFG_W-1:0] width_ff;
   logic [bfs_pkg::CFG_W-1:0] height_ff;
   logic [bfs_pkg::CNT_W-1:0] width_clamped;
   logic [bfs_pkg::CNT_W-1:0] height_clamped;
   logic                      csr_write;
   logic                      push;
   logic                      pop;
   logic                      queue_full;
   logic                      head_valid;
   bfs_pkg::bfs_desc_type     push_desc;
   bfs_pkg::bfs_desc_type     head;

   // register port: word address selects the register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bfs_pkg::CFG_W'(640);
         height_ff <= bfs_pkg::CFG_W'(480);
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            bfs_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[bfs_pkg::CFG_W-1:0];
            bfs_pkg::REG_HEIGHT: height_ff <= csr_pwdata[bfs_pkg::CFG_W-1:0];
            default:             width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         bfs_pkg::REG_WIDTH:  csr_prdata = bfs_pkg::DATA_W'(width_ff);
         bfs_pkg::REG_HEIGHT: csr_prdata = bfs_pkg::DATA_W'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // zero is used as one, oversize as the maximum; header carries the clamped value
   assign width_clamped  = bfs_pkg::clamp_dim(width_ff);
   assign height_clamped = bfs_pkg::clamp_dim(height_ff);

   bfs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .width_clamped  (width_clamped),
      .height_clamped (height_clamped),
      .queue_full     (queue_full),
      .push           (push),
      .push_desc      (push_desc)
   );

   bfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head      (head)
   );

   bfs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .width_clamped  (width_clamped),
      .height_clamped (height_clamped),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_ch         (rsp_ch)
   );

endmodule
